>>> rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg: shared types and constants of the UV-sphere tessellator
// Register indexes, reset values, fixed-point constants of the sine series
// and the side data that travels down the pipeline with each beat.
// ----------------------------------------------------------------------------
package uvs_pkg;

   // Configuration register indexes
   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_STACKS = 2'd1;
   localparam logic [1:0] REG_SLICES = 2'd2;

   // Reset values and valid range of the division counts
   localparam logic [15:0] RADIUS_RESET  = 16'd1280;
   localparam logic [6:0]  STACKS_RESET  = 7'd20;
   localparam logic [6:0]  SLICES_RESET  = 7'd20;
   localparam int unsigned MAX_DIVISIONS = 64;
   localparam logic [6:0]  MIN_STACKS    = 7'd2;
   localparam logic [6:0]  MIN_SLICES    = 7'd3;

   // Q2.30 constants
   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [63:0] Q30_HALF    = 64'h2000_0000;
   localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

   // Horner steps divide by 110, 72, 42, 20, 6: drop the power of two, then
   // multiply by a reciprocal of the odd part (exact for 31-bit operands)
   localparam int unsigned HORNER_PRE   [5] = '{1, 3, 1, 2, 1};
   localparam int unsigned HORNER_SHIFT [5] = '{37, 35, 36, 34, 33};
   localparam logic [31:0] HORNER_MAGIC [5] = '{
      32'(((64'd1 << 37) + 64'd54) / 64'd55),
      32'(((64'd1 << 35) + 64'd8) / 64'd9),
      32'(((64'd1 << 36) + 64'd20) / 64'd21),
      32'(((64'd1 << 34) + 64'd4) / 64'd5),
      32'(((64'd1 << 33) + 64'd2) / 64'd3)
   };

   // Pipeline depth of the sine unit, from angle in to magnitude out
   localparam int unsigned SINE_LAT = 19;

   // Per-beat data that rides alongside the arithmetic
   typedef struct packed {
      logic        mode;
      logic        bad;
      logic        pole_top;
      logic        pole_bot;
      logic [12:0] corner_a;
      logic [12:0] corner_b;
      logic [12:0] corner_c;
   } side_type;

endpackage

>>> rtl/uvs_div_cell.sv
// ----------------------------------------------------------------------------
// uvs_div_cell: one restoring-division step for the two angle lanes
// Each cell retires one quotient bit of phi and of theta and hands the
// partial remainder, the shifting dividend/quotient word and the side data
// to the next cell.
// ----------------------------------------------------------------------------
module uvs_div_cell #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  valid_in,
   input  uvs_pkg::side_type     side_in,
   input  logic [7:0]            divisor_phi,
   input  logic [7:0]            divisor_th,
   input  logic [7:0]            rem_phi_in,
   input  logic [ANGLE_BITS:0]   lo_phi_in,
   input  logic [7:0]            rem_th_in,
   input  logic [ANGLE_BITS:0]   lo_th_in,
   output logic                  valid_out,
   output uvs_pkg::side_type     side_out,
   output logic [7:0]            rem_phi_out,
   output logic [ANGLE_BITS:0]   lo_phi_out,
   output logic [7:0]            rem_th_out,
   output logic [ANGLE_BITS:0]   lo_th_out
);

   logic                valid_ff;
   uvs_pkg::side_type   side_ff;
   logic [7:0]          rem_phi_ff, rem_phi_in_w;
   logic [ANGLE_BITS:0] lo_phi_ff, lo_phi_in_w;
   logic [7:0]          rem_th_ff, rem_th_in_w;
   logic [ANGLE_BITS:0] lo_th_ff, lo_th_in_w;
   logic [8:0]          sh_phi, sh_th;
   logic [9:0]          diff_phi, diff_th;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      sh_phi   = {rem_phi_in, lo_phi_in[ANGLE_BITS]};
      sh_th    = {rem_th_in, lo_th_in[ANGLE_BITS]};
      diff_phi = {1'b0, sh_phi} - {2'b00, divisor_phi};
      diff_th  = {1'b0, sh_th} - {2'b00, divisor_th};
      if (!diff_phi[9]) begin
         rem_phi_in_w = diff_phi[7:0];
         lo_phi_in_w  = {lo_phi_in[ANGLE_BITS-1:0], 1'b1};
      end else begin
         rem_phi_in_w = sh_phi[7:0];
         lo_phi_in_w  = {lo_phi_in[ANGLE_BITS-1:0], 1'b0};
      end
      if (!diff_th[9]) begin
         rem_th_in_w = diff_th[7:0];
         lo_th_in_w  = {lo_th_in[ANGLE_BITS-1:0], 1'b1};
      end else begin
         rem_th_in_w = sh_th[7:0];
         lo_th_in_w  = {lo_th_in[ANGLE_BITS-1:0], 1'b0};
      end
   end

   // Advance the beat to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff    <= side_in;
         rem_phi_ff <= rem_phi_in_w;
         lo_phi_ff  <= lo_phi_in_w;
         rem_th_ff  <= rem_th_in_w;
         lo_th_ff   <= lo_th_in_w;
      end
   end

   assign valid_out   = valid_ff;
   assign side_out    = side_ff;
   assign rem_phi_out = rem_phi_ff;
   assign lo_phi_out  = lo_phi_ff;
   assign rem_th_out  = rem_th_ff;
   assign lo_th_out   = lo_th_ff;

endmodule

>>> rtl/uvs_sine.sv
// ----------------------------------------------------------------------------
// uvs_sine: pipelined sine of a binary angle
// Quadrant fold, Q2.30 argument, truncating Horner series of five steps and
// a clamp to one. Magnitude and sign come out of registers.
// ----------------------------------------------------------------------------
module uvs_sine #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS-1:0] angle,
   output logic [30:0]           mag,
   output logic                  neg
);

   localparam int unsigned QUARTER_TURN = 1 << (ANGLE_BITS - 2);
   localparam int unsigned ROUND_X      = 1 << (ANGLE_BITS - 3);
   localparam int          XPW          = ANGLE_BITS + 30;
   localparam int          NSTAGE       = 15;

   logic [ANGLE_BITS-2:0] r_in, r_ff;
   logic                  n_ff, nx_ff, nx2_ff;
   logic [XPW-1:0]        xsum;
   logic [30:0]           x_ff, x2src_ff;
   logic [63:0]           x2sum;
   logic [31:0]           x2_ff;

   logic [30:0]           cx_ff  [NSTAGE];
   logic [31:0]           cx2_ff [NSTAGE];
   logic                  cn_ff  [NSTAGE];

   logic [31:0]           v_ff [5];
   logic [63:0]           m_ff [5];
   logic [30:0]           t_ff [5];

   logic [63:0]           sprod;
   logic [30:0]           s_ff;
   logic                  sn_ff;

   // Fold onto the first quarter wave
   always_comb begin
      r_in = {1'b0, angle[ANGLE_BITS-3:0]};
      if (angle[ANGLE_BITS-2]) begin
         r_in = (ANGLE_BITS-1)'(QUARTER_TURN) - {1'b0, angle[ANGLE_BITS-3:0]};
      end
   end

   assign xsum  = XPW'(r_ff) * XPW'(uvs_pkg::PI_HALF_Q30) + XPW'(ROUND_X);
   assign x2sum = 64'(x2src_ff) * 64'(x2src_ff) + uvs_pkg::Q30_HALF;

   // Fold, scale to radians, square
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff     <= r_in;
         n_ff     <= angle[ANGLE_BITS-1];
         x2src_ff <= xsum[ANGLE_BITS+28:ANGLE_BITS-2];
         nx_ff    <= n_ff;
         x2_ff    <= x2sum[61:30];
         x_ff     <= x2src_ff;
         nx2_ff   <= nx_ff;
      end
   end

   // Carry x, x squared and sign along the series stages
   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]  <= x_ff;
         cx2_ff[0] <= x2_ff;
         cn_ff[0]  <= nx2_ff;
         for (int j = 1; j < NSTAGE; j++) begin
            cx_ff[j]  <= cx_ff[j-1];
            cx2_ff[j] <= cx2_ff[j-1];
            cn_ff[j]  <= cn_ff[j-1];
         end
      end
   end

   // Horner steps: product, reciprocal multiply, subtract from one
   for (genvar k = 0; k < 5; k++) begin : g_horner
      logic [63:0] prod;
      logic [30:0] w;
      logic [63:0] q;

      if (k == 0) begin : g_first
         assign prod = {2'b00, x2_ff, 30'd0};
      end else begin : g_rest
         assign prod = 64'(cx2_ff[3*k-1]) * 64'(t_ff[k-1]);
      end

      assign w = 31'(v_ff[k] >> uvs_pkg::HORNER_PRE[k]);
      assign q = m_ff[k] >> uvs_pkg::HORNER_SHIFT[k];

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k] <= prod[61:30];
            m_ff[k] <= 64'(w) * 64'(uvs_pkg::HORNER_MAGIC[k]);
            t_ff[k] <= uvs_pkg::Q30_ONE - q[30:0];
         end
      end
   end

   assign sprod = 64'(cx_ff[NSTAGE-1]) * 64'(t_ff[4]);

   // Final product and clamp
   always_ff @(posedge clock) begin
      if (en) begin
         if (sprod[61:30] > 32'(uvs_pkg::Q30_ONE)) begin
            s_ff <= uvs_pkg::Q30_ONE;
         end else begin
            s_ff <= sprod[60:30];
         end
         sn_ff <= cn_ff[NSTAGE-1];
      end
   end

   assign mag = s_ff;
   assign neg = sn_ff;

endmodule

>>> rtl/uv_sphere_mesh_generator_unit.sv
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator_unit: UV-sphere vertex and triangle generator
// Each request beat yields one response beat: a vertex position in signed
// Q8.8 or the three vertex indices of one triangle, with an error flag.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle and returns responses in order: the
// angles come from a row of ANGLE_BITS + 1 restoring-division cells, one
// quotient bit per cell, followed by a 19-stage sine pipeline and two
// scaling stages. The whole pipeline halts while a response waits on
// rsp_ready. Configuration writes are to take effect only for requests
// accepted after the pipeline has drained; the user ensures it, not the unit.
module uv_sphere_mesh_generator_unit #(
   parameter int ANGLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [6:0]         req_ring,
   input  logic [6:0]         req_segment,
   input  logic               req_half,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic [12:0]        rsp_corner_a,
   output logic [12:0]        rsp_corner_b,
   output logic [12:0]        rsp_corner_c,
   output logic               rsp_bad_request
);

   localparam int NCELL = ANGLE_BITS + 1;
   localparam int DW    = ANGLE_BITS + 7;
   localparam int QUARTER_TURN = 1 << (ANGLE_BITS - 2);
   localparam int LAT   = uvs_pkg::SINE_LAT;

   logic [15:0] radius_ff;
   logic [6:0]  stacks_ff, slices_ff;
   logic        en;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= uvs_pkg::RADIUS_RESET;
         stacks_ff <= uvs_pkg::STACKS_RESET;
         slices_ff <= uvs_pkg::SLICES_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            uvs_pkg::REG_RADIUS: radius_ff <= csr_write_data;
            uvs_pkg::REG_STACKS: stacks_ff <= csr_write_data[6:0];
            uvs_pkg::REG_SLICES: slices_ff <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   // Advance everything unless a response is held
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Decode the request: range check, poles and triangle indices
   logic              cfg_ok;
   uvs_pkg::side_type side_new;
   logic [15:0]       rlen, south, base, up, dn;
   logic [6:0]        stk_m1, ring_m1;
   logic [DW-1:0]     dvd_phi, dvd_th;

   always_comb begin
      cfg_ok = stacks_ff >= uvs_pkg::MIN_STACKS &&
               stacks_ff <= 7'(uvs_pkg::MAX_DIVISIONS) &&
               slices_ff >= uvs_pkg::MIN_SLICES &&
               slices_ff <= 7'(uvs_pkg::MAX_DIVISIONS);
      rlen    = 16'(slices_ff) + 16'd1;
      stk_m1  = stacks_ff - 7'd1;
      ring_m1 = req_ring - 7'd1;
      south   = 16'd1 + rlen * 16'(stk_m1);
      base    = south - rlen;
      up      = 16'd1 + 16'(ring_m1) * rlen + 16'(req_segment);
      dn      = up + rlen;

      side_new          = '0;
      side_new.mode     = req_mode;
      side_new.pole_top = (req_ring == 7'd0);
      side_new.pole_bot = (req_ring == stacks_ff);
      if (req_mode) begin
         side_new.bad = !cfg_ok || req_ring >= stacks_ff || req_segment >= slices_ff;
      end else begin
         side_new.bad = !cfg_ok || req_ring > stacks_ff || req_segment > slices_ff;
      end

      if (req_mode && !side_new.bad) begin
         if (req_ring == 7'd0) begin
            side_new.corner_a = 13'd0;
            side_new.corner_b = 13'(req_segment) + 13'd2;
            side_new.corner_c = 13'(req_segment) + 13'd1;
         end else if (req_ring == stk_m1) begin
            side_new.corner_a = south[12:0];
            side_new.corner_b = 13'(base + 16'(req_segment));
            side_new.corner_c = 13'(base + 16'(req_segment) + 16'd1);
         end else if (!req_half) begin
            side_new.corner_a = up[12:0];
            side_new.corner_b = 13'(up + 16'd1);
            side_new.corner_c = dn[12:0];
         end else begin
            side_new.corner_a = dn[12:0];
            side_new.corner_b = 13'(up + 16'd1);
            side_new.corner_c = 13'(dn + 16'd1);
         end
      end

      dvd_phi = {req_ring, ANGLE_BITS'(0)} + DW'(stacks_ff);
      dvd_th  = {req_segment, ANGLE_BITS'(0)} + DW'(slices_ff[6:1]);
   end

   // Division chain for phi = ring/(2 stacks) and theta = segment/slices
   logic                cv   [NCELL+1];
   uvs_pkg::side_type   cs   [NCELL+1];
   logic [7:0]          crp  [NCELL+1];
   logic [ANGLE_BITS:0] clp  [NCELL+1];
   logic [7:0]          crt  [NCELL+1];
   logic [ANGLE_BITS:0] clt  [NCELL+1];

   assign cv[0]  = req_valid;
   assign cs[0]  = side_new;
   assign crp[0] = {2'b00, dvd_phi[DW-1:ANGLE_BITS+1]};
   assign clp[0] = dvd_phi[ANGLE_BITS:0];
   assign crt[0] = {2'b00, dvd_th[DW-1:ANGLE_BITS+1]};
   assign clt[0] = dvd_th[ANGLE_BITS:0];

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      uvs_div_cell #(.ANGLE_BITS(ANGLE_BITS)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .en          (en),
         .valid_in    (cv[i]),
         .side_in     (cs[i]),
         .divisor_phi ({stacks_ff, 1'b0}),
         .divisor_th  ({1'b0, slices_ff}),
         .rem_phi_in  (crp[i]),
         .lo_phi_in   (clp[i]),
         .rem_th_in   (crt[i]),
         .lo_th_in    (clt[i]),
         .valid_out   (cv[i+1]),
         .side_out    (cs[i+1]),
         .rem_phi_out (crp[i+1]),
         .lo_phi_out  (clp[i+1]),
         .rem_th_out  (crt[i+1]),
         .lo_th_out   (clt[i+1])
      );
   end

   // Four sines: sin phi, cos phi, sin theta, cos theta
   logic [ANGLE_BITS-1:0] a_sp, a_cp, a_st, a_ct;
   logic [30:0]           m_sp, m_cp, m_st, m_ct;
   logic                  n_sp, n_cp, n_st, n_ct;

   assign a_sp = clp[NCELL][ANGLE_BITS-1:0];
   assign a_cp = clp[NCELL][ANGLE_BITS-1:0] + ANGLE_BITS'(QUARTER_TURN);
   assign a_st = clt[NCELL][ANGLE_BITS-1:0];
   assign a_ct = clt[NCELL][ANGLE_BITS-1:0] + ANGLE_BITS'(QUARTER_TURN);

   uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_phi (
      .clock (clock), .en (en), .angle (a_sp), .mag (m_sp), .neg (n_sp));
   uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_phi (
      .clock (clock), .en (en), .angle (a_cp), .mag (m_cp), .neg (n_cp));
   uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_th (
      .clock (clock), .en (en), .angle (a_st), .mag (m_st), .neg (n_st));
   uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_th (
      .clock (clock), .en (en), .angle (a_ct), .mag (m_ct), .neg (n_ct));

   // Delay line for side data across the sine pipeline
   logic              dl_valid_ff [LAT];
   uvs_pkg::side_type dl_side_ff  [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LAT; j++) begin
            dl_valid_ff[j] <= 1'b0;
         end
      end else if (en) begin
         dl_valid_ff[0] <= cv[NCELL];
         for (int j = 1; j < LAT; j++) begin
            dl_valid_ff[j] <= dl_valid_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_side_ff[0] <= cs[NCELL];
         for (int j = 1; j < LAT; j++) begin
            dl_side_ff[j] <= dl_side_ff[j-1];
         end
      end
   end

   // Combine sin phi with the theta terms
   logic              f1_valid_ff;
   uvs_pkg::side_type f1_side_ff;
   logic [30:0]       px_ff, pz_ff, cp_ff;
   logic              nx_ff, ny_ff, nz_ff;
   logic [63:0]       px_sum, pz_sum;

   assign px_sum = 64'(m_sp) * 64'(m_ct) + uvs_pkg::Q30_HALF;
   assign pz_sum = 64'(m_sp) * 64'(m_st) + uvs_pkg::Q30_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= dl_valid_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_side_ff <= dl_side_ff[LAT-1];
         px_ff      <= px_sum[60:30];
         pz_ff      <= pz_sum[60:30];
         cp_ff      <= m_cp;
         nx_ff      <= n_sp ^ n_ct;
         ny_ff      <= n_cp;
         nz_ff      <= n_sp ^ n_st;
      end
   end

   // Scale by the radius, apply signs and pick the response fields
   logic [47:0]        sx, sy, sz;
   logic [16:0]        mx, my, mz;
   logic signed [16:0] pos_x_in, pos_y_in, pos_z_in;
   logic [12:0]        ca_in, cb_in, cc_in;
   logic               bad_in;

   always_comb begin
      sx = 48'(radius_ff) * 48'(px_ff) + 48'(uvs_pkg::Q30_HALF);
      sy = 48'(radius_ff) * 48'(cp_ff) + 48'(uvs_pkg::Q30_HALF);
      sz = 48'(radius_ff) * 48'(pz_ff) + 48'(uvs_pkg::Q30_HALF);
      mx = {1'b0, sx[45:30]};
      my = {1'b0, sy[45:30]};
      mz = {1'b0, sz[45:30]};

      pos_x_in = '0;
      pos_y_in = '0;
      pos_z_in = '0;
      ca_in    = '0;
      cb_in    = '0;
      cc_in    = '0;
      bad_in   = f1_side_ff.bad;
      if (!f1_side_ff.bad) begin
         if (f1_side_ff.mode) begin
            ca_in = f1_side_ff.corner_a;
            cb_in = f1_side_ff.corner_b;
            cc_in = f1_side_ff.corner_c;
         end else if (f1_side_ff.pole_top) begin
            pos_y_in = {1'b0, radius_ff};
         end else if (f1_side_ff.pole_bot) begin
            pos_y_in = -{1'b0, radius_ff};
         end else begin
            pos_x_in = nx_ff ? -mx : mx;
            pos_y_in = ny_ff ? -my : my;
            pos_z_in = nz_ff ? -mz : mz;
         end
      end
   end

   // Output register
   logic               rsp_valid_ff;
   logic signed [16:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [12:0]        ca_ff, cb_ff, cc_ff;
   logic               bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         ca_ff    <= ca_in;
         cb_ff    <= cb_in;
         cc_ff    <= cc_in;
         bad_ff   <= bad_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_pos_z       = pos_z_ff;
   assign rsp_corner_a    = ca_ff;
   assign rsp_corner_b    = cb_ff;
   assign rsp_corner_c    = cc_ff;
   assign rsp_bad_request = bad_ff;

endmodule
